// ----- rtl/core/psq_pkg.sv -----
// psq_pkg: shared types and constants of the prime square test block
// state encoding and the command/status bundles between controller and datapath
// no dependencies
package psq_pkg;

	localparam int ROOT_BITS_DEF = 20;

	typedef enum logic [2:0] {
		S_FILL,
		S_SV_RD,
		S_SV_CHK,
		S_SV_CLR,
		S_IDLE,
		S_ROOT,
		S_LOOK,
		S_RES
	} state_t;

	typedef struct packed {
		logic fill_step;
		logic sieve_init;
		logic sieve_rd;
		logic next_i;
		logic clr_step;
		logic load;
		logic root_step;
		logic look_rd;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic fill_last;
		logic sieve_end;
		logic map_bit;
		logic clr_last;
		logic root_last;
	} sts_t;

endpackage

// ----- rtl/core/psq_ram.sv -----
// psq_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module psq_ram #(
	parameter int          WIDTH = 1,
	parameter longint      DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/psq_ctrl.sv -----
// psq_ctrl: controller state machine, sieve after reset then one root search per transaction
// depends on psq_pkg
module psq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  psq_pkg::sts_t  sts,
	output psq_pkg::cmd_t  cmd,
	output logic           busy
);

	psq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psq_pkg::S_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			psq_pkg::S_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_last) begin
					cmd.sieve_init = 1'b1;
					state_d        = psq_pkg::S_SV_RD;
				end
			end
			psq_pkg::S_SV_RD: begin
				if (sts.sieve_end) begin
					state_d = psq_pkg::S_IDLE;
				end else begin
					cmd.sieve_rd = 1'b1;
					state_d      = psq_pkg::S_SV_CHK;
				end
			end
			psq_pkg::S_SV_CHK: begin
				if (sts.map_bit) begin
					state_d = psq_pkg::S_SV_CLR;
				end else begin
					cmd.next_i = 1'b1;
					state_d    = psq_pkg::S_SV_RD;
				end
			end
			psq_pkg::S_SV_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					cmd.next_i = 1'b1;
					state_d    = psq_pkg::S_SV_RD;
				end
			end
			psq_pkg::S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = psq_pkg::S_ROOT;
				end
			end
			psq_pkg::S_ROOT: begin
				cmd.root_step = 1'b1;
				if (sts.root_last) begin
					state_d = psq_pkg::S_LOOK;
				end
			end
			psq_pkg::S_LOOK: begin
				cmd.look_rd = 1'b1;
				state_d     = psq_pkg::S_RES;
			end
			psq_pkg::S_RES: begin
				cmd.finish = 1'b1;
				state_d    = psq_pkg::S_IDLE;
			end
			default: begin
				state_d = psq_pkg::S_FILL;
			end
		endcase
	end

	assign busy = (state_q != psq_pkg::S_IDLE);

endmodule

// ----- rtl/core/psq_dp.sv -----
// psq_dp: datapath with sieve counters, digit-by-digit square root unit and the prime map
// depends on psq_pkg and psq_ram
module psq_dp #(
	parameter int ROOT_BITS = psq_pkg::ROOT_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [2*ROOT_BITS-1:0]   value,
	input  psq_pkg::cmd_t            cmd,
	output psq_pkg::sts_t            sts,
	output logic                     done,
	output logic                     is_prime_square
);

	localparam int     IW    = (ROOT_BITS + 1) / 2 + 1;
	localparam int     CW    = $clog2(ROOT_BITS);
	localparam longint DEPTH = 64'(1) << ROOT_BITS;

	// sieve
	logic [ROOT_BITS-1:0] fill_q;
	logic [IW-1:0]        i_q;
	logic [ROOT_BITS:0]   sq_q;
	logic [ROOT_BITS:0]   j_q;
	logic [ROOT_BITS:0]   j_sum;

	// root unit
	logic [2*ROOT_BITS-1:0] n_q;
	logic [ROOT_BITS:0]     rem_q;
	logic [ROOT_BITS-1:0]   root_q;
	logic [CW-1:0]          cnt_q;
	logic [ROOT_BITS+2:0]   shifted;
	logic [ROOT_BITS+2:0]   trial;
	logic [ROOT_BITS+2:0]   diff;
	logic                   ge;

	// map port
	logic                 we;
	logic [ROOT_BITS-1:0] waddr;
	logic                 wdata;
	logic                 re;
	logic [ROOT_BITS-1:0] raddr;
	logic                 rdata;

	logic done_q;
	logic result_q;

	assign j_sum = j_q + (ROOT_BITS+1)'(i_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.fill_step) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sieve_init) begin
			i_q  <= IW'(2);
			sq_q <= (ROOT_BITS+1)'(4);
		end else if (cmd.next_i) begin
			i_q  <= i_q + 1'b1;
			sq_q <= sq_q + (ROOT_BITS+1)'({i_q, 1'b1});
		end
		if (cmd.sieve_rd) begin
			j_q <= sq_q;
		end else if (cmd.clr_step) begin
			j_q <= j_sum;
		end
	end

	// one result bit per step: bring down two value bits, try (root << 2) | 1
	assign shifted = {rem_q, n_q[2*ROOT_BITS-1 -: 2]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign ge      = (shifted >= trial);
	assign diff    = shifted - trial;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= value;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= CW'(ROOT_BITS - 1);
		end else if (cmd.root_step) begin
			n_q    <= {n_q[2*ROOT_BITS-3:0], 2'b00};
			rem_q  <= ge ? diff[ROOT_BITS:0] : shifted[ROOT_BITS:0];
			root_q <= {root_q[ROOT_BITS-2:0], ge};
			cnt_q  <= cnt_q - 1'b1;
		end
	end

	// fill writes 1 everywhere but 0 and 1, strike-out writes 0
	assign we    = cmd.fill_step | cmd.clr_step;
	assign waddr = cmd.fill_step ? fill_q : j_q[ROOT_BITS-1:0];
	assign wdata = cmd.fill_step & (|fill_q[ROOT_BITS-1:1]);
	assign re    = cmd.sieve_rd | cmd.look_rd;
	assign raddr = cmd.look_rd ? root_q : ROOT_BITS'(i_q);

	psq_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q <= (rem_q == '0) & rdata;
		end
	end

	assign sts.fill_last = &fill_q;
	assign sts.sieve_end = sq_q[ROOT_BITS];
	assign sts.map_bit   = rdata;
	assign sts.clr_last  = j_sum[ROOT_BITS];
	assign sts.root_last = (cnt_q == '0);

	assign done            = done_q;
	assign is_prime_square = result_q;

endmodule

// ----- rtl/core/prime_square_test_top.sv -----
// prime_square_test_top: tests whether a value is the square of a prime
// operation: an accepted start loads the value, the root unit forms the root, the map is read at the root,
// and the result is then registered together with done
// root unit: shared, one bit a cycle; a new value is accepted only once the last result is out
// reset: the prime map is filled then sieved and busy stays high throughout; results cannot be stalled
module prime_square_test_top #(
	parameter int ROOT_BITS = psq_pkg::ROOT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [2*ROOT_BITS-1:0] value,
	output logic                   done,
	output logic                   is_prime_square
);

	psq_pkg::cmd_t cmd;
	psq_pkg::sts_t sts;

	psq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	psq_dp #(
		.ROOT_BITS (ROOT_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.value           (value),
		.cmd             (cmd),
		.sts             (sts),
		.done            (done),
		.is_prime_square (is_prime_square)
	);

`ifndef NO_ASSERTIONS
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(ROOT_BITS+3) done)
		else $error("result not delivered at the expected cycle");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a transaction is still in progress");
`endif

endmodule
